// File: rtl/serial_traffic_statistics_assert.svh
// Assertion macros shared by the statistics block.
`ifndef SERIAL_TRAFFIC_STATISTICS_ASSERT_SVH
`define SERIAL_TRAFFIC_STATISTICS_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define STS_ASSERT_NOW(name, clk, rstn, pre, post) \
    name: assert property (@(posedge clk) disable iff (!(rstn)) (pre) |-> (post)) \
        else $error("statistics assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define STS_ASSERT_NEXT(name, clk, rstn, pre, post) \
    name: assert property (@(posedge clk) disable iff (!(rstn)) (pre) |=> (post)) \
        else $error("statistics assertion failed");

`endif

// File: rtl/sts_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package sts_pkg;

    localparam int BIN_COUNT      = 256;
    localparam int BYTE_WIDTH     = 8;
    localparam int KIND_WIDTH     = 2;
    localparam int SIZE_MAX_WIDTH = 32;
    localparam int GAP_WIDTH      = 32;
    localparam int SUM_WIDTH      = 48;
    localparam int QUEUE_DEPTH    = 2;

    typedef enum logic [KIND_WIDTH-1:0] {
        KIND_BYTE   = 2'd0,
        KIND_PACKET = 2'd1,
        KIND_GAP    = 2'd2,
        KIND_CLEAR  = 2'd3
    } t_kind;

    // One-hot event class produced by the front end.
    typedef struct packed {
        logic is_byte;
        logic is_pkt;
        logic is_gap;
        logic is_clr;
    } t_op;

    typedef struct packed {
        t_op                       op;
        logic [BYTE_WIDTH-1:0]     byte_value;
        logic [SIZE_MAX_WIDTH-1:0] packet_size;
        logic                      pkt_err;
        logic [GAP_WIDTH-1:0]      gap_us;
    } t_cmd;

endpackage

`default_nettype wire

// File: rtl/sts_fifo.sv
`timescale 1ns / 1ps
`default_nettype none

module sts_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_din,
    output logic                  o_full,
    input  wire logic             i_pop,
    output logic [WIDTH-1:0]      o_dout,
    output logic                  o_empty
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wptr, n_wptr;
    logic [PW-1:0]    r_rptr, n_rptr;
    logic [CW-1:0]    r_count, n_count;
    logic             push_ok;
    logic             pop_ok;

    function automatic logic [PW-1:0] f_next(input logic [PW-1:0] p);
        return (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
    endfunction

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign push_ok = i_push && !o_full;
    assign pop_ok  = i_pop && !o_empty;
    assign o_dout  = r_mem[r_rptr];

    always_comb begin
        n_wptr  = push_ok ? f_next(r_wptr) : r_wptr;
        n_rptr  = pop_ok ? f_next(r_rptr) : r_rptr;
        n_count = r_count;
        if (push_ok && !pop_ok) begin
            n_count = r_count + CW'(1);
        end else if (pop_ok && !push_ok) begin
            n_count = r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_mem[r_wptr] <= i_din;
        end
    end

endmodule

`default_nettype wire

// File: rtl/sts_front.sv
`timescale 1ns / 1ps
`default_nettype none

module sts_front #(
    parameter int SIZE_WIDTH = 16
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_push,
    output logic                                     o_full,
    input  wire logic [sts_pkg::KIND_WIDTH-1:0]      i_kind,
    input  wire logic [sts_pkg::BYTE_WIDTH-1:0]      i_byte_value,
    input  wire logic [SIZE_WIDTH-1:0]               i_packet_size,
    input  wire logic                                i_pkt_err,
    input  wire logic [sts_pkg::GAP_WIDTH-1:0]       i_gap_us,
    output logic                                     o_valid,
    output sts_pkg::t_cmd                            o_cmd,
    input  wire logic                                i_take
);

    localparam int SMW = sts_pkg::SIZE_MAX_WIDTH;

    sts_pkg::t_cmd cmd;
    logic          q_empty;

    // Decode the event kind into a one-hot class for the execute side.
    always_comb begin
        cmd             = '0;
        cmd.byte_value  = i_byte_value;
        cmd.packet_size = SMW'(i_packet_size);
        cmd.pkt_err     = i_pkt_err;
        cmd.gap_us      = i_gap_us;
        case (sts_pkg::t_kind'(i_kind))
            sts_pkg::KIND_BYTE:   cmd.op.is_byte = 1'b1;
            sts_pkg::KIND_PACKET: cmd.op.is_pkt  = 1'b1;
            sts_pkg::KIND_GAP:    cmd.op.is_gap  = 1'b1;
            sts_pkg::KIND_CLEAR:  cmd.op.is_clr  = 1'b1;
            default:              cmd.op.is_clr  = 1'b1;
        endcase
    end

    sts_fifo #(
        .WIDTH ($bits(sts_pkg::t_cmd)),
        .DEPTH (sts_pkg::QUEUE_DEPTH)
    ) u_cmd_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_push),
        .i_din   (cmd),
        .o_full  (o_full),
        .i_pop   (i_take),
        .o_dout  (o_cmd),
        .o_empty (q_empty)
    );

    assign o_valid = !q_empty;

endmodule

`default_nettype wire

// File: rtl/sts_back.sv
`timescale 1ns / 1ps
`default_nettype none

`include "serial_traffic_statistics_assert.svh"

module sts_back #(
    parameter int COUNTER_WIDTH = 32,
    parameter int SIZE_WIDTH    = 16
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_valid,
    input  wire sts_pkg::t_cmd                      i_cmd,
    output logic                                    o_take,
    output logic                                    o_empty,
    input  wire logic                               i_pop,
    output logic [COUNTER_WIDTH-1:0]                o_byte_total,
    output logic [COUNTER_WIDTH-1:0]                o_packet_total,
    output logic [COUNTER_WIDTH-1:0]                o_good_packets,
    output logic [COUNTER_WIDTH-1:0]                o_bad_packets,
    output logic [SIZE_WIDTH-1:0]                   o_smallest_size,
    output logic [SIZE_WIDTH-1:0]                   o_largest_size,
    output logic [sts_pkg::SUM_WIDTH-1:0]           o_size_sum,
    output logic [COUNTER_WIDTH-1:0]                o_gap_total,
    output logic [sts_pkg::SUM_WIDTH-1:0]           o_gap_sum,
    output logic [sts_pkg::GAP_WIDTH-1:0]           o_longest_gap,
    output logic [sts_pkg::BYTE_WIDTH-1:0]          o_top_byte
);

    localparam int CW   = COUNTER_WIDTH;
    localparam int SW   = SIZE_WIDTH;
    localparam int AW   = sts_pkg::SUM_WIDTH;
    localparam int GW   = sts_pkg::GAP_WIDTH;
    localparam int BW   = sts_pkg::BYTE_WIDTH;
    localparam int SUMW = AW + 1;

    typedef struct packed {
        logic [CW-1:0] bytes;
        logic [CW-1:0] pkts;
        logic [CW-1:0] good;
        logic [CW-1:0] bad;
        logic [SW-1:0] size_low;
        logic [SW-1:0] size_high;
        logic [AW-1:0] size_sum;
        logic [CW-1:0] gaps;
        logic [AW-1:0] gap_sum;
        logic [GW-1:0] gap_peak;
        logic [BW-1:0] leader;
    } t_snap;

    // Histogram memory and its per-bin valid flags.
    logic [CW-1:0]                 r_mem [sts_pkg::BIN_COUNT];
    logic [CW-1:0]                 r_rd;
    logic [sts_pkg::BIN_COUNT-1:0] r_bin_valid;

    // Last histogram write, used to forward past the read latency.
    logic          r_fwd_ok;
    logic [BW-1:0] r_fwd_addr;
    logic [CW-1:0] r_fwd_val;

    // Execute stage.
    logic          r_b_valid;
    sts_pkg::t_cmd r_b;
    logic          b_adv;
    logic          res_full;

    t_snap         r_st;
    t_snap         n_st;
    t_snap         res_snap;
    logic [CW-1:0] r_leader_count, n_leader_count;

    logic [CW-1:0]   bin_cur;
    logic [CW-1:0]   bin_next;
    logic            fwd_hit;
    logic [SW-1:0]   sz;
    logic [SUMW-1:0] size_add;
    logic [SUMW-1:0] gap_add;

    function automatic logic [CW-1:0] f_sat_inc(input logic [CW-1:0] x);
        return (x == {CW{1'b1}}) ? x : x + CW'(1);
    endfunction

    // Statistics as they stand after reset or a clear.
    function automatic t_snap f_cleared();
        t_snap s;
        s          = '0;
        s.size_low = '1;
        return s;
    endfunction

    assign b_adv  = r_b_valid && !res_full;
    assign o_take = i_valid && (!r_b_valid || b_adv);

    assign fwd_hit  = r_fwd_ok && (r_fwd_addr == r_b.byte_value);
    assign bin_cur  = r_bin_valid[r_b.byte_value] ? (fwd_hit ? r_fwd_val : r_rd) : '0;
    assign bin_next = f_sat_inc(bin_cur);

    assign sz       = r_b.packet_size[SW-1:0];
    assign size_add = {1'b0, r_st.size_sum} + SUMW'(sz);
    assign gap_add  = {1'b0, r_st.gap_sum} + SUMW'(r_b.gap_us);

    always_comb begin
        n_st           = r_st;
        n_leader_count = r_leader_count;
        if (r_b.op.is_clr) begin
            n_st           = f_cleared();
            n_leader_count = '0;
        end else if (r_b.op.is_byte) begin
            n_st.bytes = f_sat_inc(r_st.bytes);
            if ((bin_next > r_leader_count) ||
                ((bin_next == r_leader_count) && (r_b.byte_value < r_st.leader))) begin
                n_leader_count = bin_next;
                n_st.leader    = r_b.byte_value;
            end
        end else if (r_b.op.is_pkt) begin
            n_st.pkts = f_sat_inc(r_st.pkts);
            if (r_b.pkt_err) begin
                n_st.bad = f_sat_inc(r_st.bad);
            end else begin
                n_st.good = f_sat_inc(r_st.good);
            end
            if (sz < r_st.size_low) begin
                n_st.size_low = sz;
            end
            if (sz > r_st.size_high) begin
                n_st.size_high = sz;
            end
            n_st.size_sum = size_add[AW] ? '1 : size_add[AW-1:0];
        end else if (r_b.op.is_gap) begin
            n_st.gaps    = f_sat_inc(r_st.gaps);
            n_st.gap_sum = gap_add[AW] ? '1 : gap_add[AW-1:0];
            if (r_b.gap_us > r_st.gap_peak) begin
                n_st.gap_peak = r_b.gap_us;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid        <= 1'b0;
            r_fwd_ok         <= 1'b0;
            r_bin_valid      <= '0;
            r_st             <= f_cleared();
            r_leader_count   <= '0;
        end else begin
            if (o_take) begin
                r_b_valid <= 1'b1;
            end else if (b_adv) begin
                r_b_valid <= 1'b0;
            end
            if (b_adv) begin
                r_st           <= n_st;
                r_leader_count <= n_leader_count;
                if (r_b.op.is_clr) begin
                    r_bin_valid <= '0;
                end else if (r_b.op.is_byte) begin
                    r_bin_valid[r_b.byte_value] <= 1'b1;
                    r_fwd_ok                    <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take) begin
            r_b  <= i_cmd;
            r_rd <= r_mem[i_cmd.byte_value];
        end
        if (b_adv && r_b.op.is_byte) begin
            r_mem[r_b.byte_value] <= bin_next;
            r_fwd_addr            <= r_b.byte_value;
            r_fwd_val             <= bin_next;
        end
    end

    sts_fifo #(
        .WIDTH ($bits(t_snap)),
        .DEPTH (sts_pkg::QUEUE_DEPTH)
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (b_adv),
        .i_din   (n_st),
        .o_full  (res_full),
        .i_pop   (i_pop),
        .o_dout  (res_snap),
        .o_empty (o_empty)
    );

    assign o_byte_total    = res_snap.bytes;
    assign o_packet_total  = res_snap.pkts;
    assign o_good_packets  = res_snap.good;
    assign o_bad_packets   = res_snap.bad;
    assign o_smallest_size = res_snap.size_low;
    assign o_largest_size  = res_snap.size_high;
    assign o_size_sum      = res_snap.size_sum;
    assign o_gap_total     = res_snap.gaps;
    assign o_gap_sum       = res_snap.gap_sum;
    assign o_longest_gap   = res_snap.gap_peak;
    assign o_top_byte      = res_snap.leader;

    `STS_ASSERT_NEXT(a_bin_marked, i_clk, i_rst_n, b_adv && r_b.op.is_byte,
        r_bin_valid[$past(r_b.byte_value)])
    `STS_ASSERT_NEXT(a_clear_bins, i_clk, i_rst_n, b_adv && r_b.op.is_clr,
        r_bin_valid == '0)
    `STS_ASSERT_NOW(a_leader_bound, i_clk, i_rst_n, 1'b1, r_leader_count <= r_st.bytes)
    `STS_ASSERT_NOW(a_size_order, i_clk, i_rst_n, r_st.pkts != '0,
        r_st.size_low <= r_st.size_high)

endmodule

`default_nettype wire

// File: rtl/serial_traffic_statistics.sv
// Event path: command queue, execute stage register, result queue. Throughput: one event
// per cycle while the result queue has room, set by the histogram read-modify-write,
// which reads at the command queue head and writes in the execute stage with last-write
// forwarding. Reset: synchronous, active low; all statistics, bin valid flags and both
// queues clear together, with no clearing pass over the histogram memory.
`timescale 1ns / 1ps
`default_nettype none

// The block is split into a front end that accepts and classifies event beats into a
// short command queue, and an execute side that updates the histogram and the running
// statistics and pushes one snapshot per event into a result queue. Either queue lets
// its side stall while the other keeps moving.
module serial_traffic_statistics #(
    parameter int COUNTER_WIDTH = 32,
    parameter int SIZE_WIDTH    = 16
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    // Event side.
    input  wire logic                               push,
    output logic                                    full,
    input  wire logic [sts_pkg::KIND_WIDTH-1:0]     i_kind,
    input  wire logic [sts_pkg::BYTE_WIDTH-1:0]     i_byte_value,
    input  wire logic [SIZE_WIDTH-1:0]              i_packet_size,
    input  wire logic                               i_pkt_err,
    input  wire logic [sts_pkg::GAP_WIDTH-1:0]      i_gap_us,
    // Snapshot side.
    output logic                                    empty,
    input  wire logic                               pop,
    output logic [COUNTER_WIDTH-1:0]                o_byte_total,
    output logic [COUNTER_WIDTH-1:0]                o_packet_total,
    output logic [COUNTER_WIDTH-1:0]                o_good_packets,
    output logic [COUNTER_WIDTH-1:0]                o_bad_packets,
    output logic [SIZE_WIDTH-1:0]                   o_smallest_size,
    output logic [SIZE_WIDTH-1:0]                   o_largest_size,
    output logic [sts_pkg::SUM_WIDTH-1:0]           o_size_sum,
    output logic [COUNTER_WIDTH-1:0]                o_gap_total,
    output logic [sts_pkg::SUM_WIDTH-1:0]           o_gap_sum,
    output logic [sts_pkg::GAP_WIDTH-1:0]           o_longest_gap,
    output logic [sts_pkg::BYTE_WIDTH-1:0]          o_top_byte
);

    // Command handoff between the two halves.
    logic          cmd_valid;
    logic          cmd_take;
    sts_pkg::t_cmd cmd;

    // The front end decodes the kind field into a one-hot class and widens the packet
    // size so that the command queue has a fixed layout.
    sts_front #(
        .SIZE_WIDTH (SIZE_WIDTH)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_push        (push),
        .o_full        (full),
        .i_kind        (i_kind),
        .i_byte_value  (i_byte_value),
        .i_packet_size (i_packet_size),
        .i_pkt_err     (i_pkt_err),
        .i_gap_us      (i_gap_us),
        .o_valid       (cmd_valid),
        .o_cmd         (cmd),
        .i_take        (cmd_take)
    );

    // The execute side issues the histogram read when it takes a command from the queue
    // and finishes the update in the execute stage. A bin written on the edge the command
    // entered is taken from the forwarding register instead of the stale read data.
    // A bin whose valid flag is clear reads as zero, which is how a clear empties the
    // histogram at once.
    sts_back #(
        .COUNTER_WIDTH (COUNTER_WIDTH),
        .SIZE_WIDTH    (SIZE_WIDTH)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (cmd_valid),
        .i_cmd           (cmd),
        .o_take          (cmd_take),
        .o_empty         (empty),
        .i_pop           (pop),
        .o_byte_total    (o_byte_total),
        .o_packet_total  (o_packet_total),
        .o_good_packets  (o_good_packets),
        .o_bad_packets   (o_bad_packets),
        .o_smallest_size (o_smallest_size),
        .o_largest_size  (o_largest_size),
        .o_size_sum      (o_size_sum),
        .o_gap_total     (o_gap_total),
        .o_gap_sum       (o_gap_sum),
        .o_longest_gap   (o_longest_gap),
        .o_top_byte      (o_top_byte)
    );

endmodule

`default_nettype wire

// File: tb/tb.sv
`timescale 1ns / 1ps

// Widths of the block as instantiated here (default parameters).
localparam int STAT_COUNT_WIDTH = 32;
localparam int STAT_SIZE_WIDTH  = 16;

// One event beat as offered on the input side.
typedef struct {
    sts_pkg::t_kind                   kind;
    logic [sts_pkg::BYTE_WIDTH-1:0]   byte_value;
    logic [STAT_SIZE_WIDTH-1:0]       packet_size;
    logic                             pkt_err;
    logic [sts_pkg::GAP_WIDTH-1:0]    gap_us;
} t_traffic_item;

// One statistics snapshot as seen on the result side.
typedef struct {
    logic [STAT_COUNT_WIDTH-1:0]      byte_total;
    logic [STAT_COUNT_WIDTH-1:0]      packet_total;
    logic [STAT_COUNT_WIDTH-1:0]      good_packets;
    logic [STAT_COUNT_WIDTH-1:0]      bad_packets;
    logic [STAT_SIZE_WIDTH-1:0]       smallest_size;
    logic [STAT_SIZE_WIDTH-1:0]       largest_size;
    logic [sts_pkg::SUM_WIDTH-1:0]    size_sum;
    logic [STAT_COUNT_WIDTH-1:0]      gap_total;
    logic [sts_pkg::SUM_WIDTH-1:0]    gap_sum;
    logic [sts_pkg::GAP_WIDTH-1:0]    longest_gap;
    logic [sts_pkg::BYTE_WIDTH-1:0]   top_byte;
} t_stats_snapshot;

// Keeps its own copy of the traffic statistics, derives the snapshot that each
// accepted event beat should produce, and compares the snapshots coming out.
class traffic_tally;
    t_stats_snapshot                 pending_snapshots[$];
    int                              mismatch_count;

    logic [STAT_COUNT_WIDTH-1:0]     bin_hits[sts_pkg::BIN_COUNT];
    bit                              bin_seen[sts_pkg::BIN_COUNT];
    logic [sts_pkg::BYTE_WIDTH-1:0]  leader_value;
    logic [STAT_COUNT_WIDTH-1:0]     leader_hits;
    t_stats_snapshot                 now;

    function new();
        mismatch_count = 0;
        wipe();
    endfunction

    function void wipe();
        foreach (bin_seen[i]) begin
            bin_seen[i] = 1'b0;
            bin_hits[i] = '0;
        end
        leader_value      = '0;
        leader_hits       = '0;
        now.byte_total    = '0;
        now.packet_total  = '0;
        now.good_packets  = '0;
        now.bad_packets   = '0;
        now.smallest_size = '1;
        now.largest_size  = '0;
        now.size_sum      = '0;
        now.gap_total     = '0;
        now.gap_sum       = '0;
        now.longest_gap   = '0;
        now.top_byte      = '0;
    endfunction

    function logic [STAT_COUNT_WIDTH-1:0] bump(logic [STAT_COUNT_WIDTH-1:0] x);
        return (x == '1) ? x : x + STAT_COUNT_WIDTH'(1);
    endfunction

    function logic [sts_pkg::SUM_WIDTH-1:0] add_capped(logic [sts_pkg::SUM_WIDTH-1:0] acc,
                                                       logic [sts_pkg::SUM_WIDTH-1:0] v);
        logic [sts_pkg::SUM_WIDTH:0] s;
        s = {1'b0, acc} + {1'b0, v};
        return s[sts_pkg::SUM_WIDTH] ? '1 : s[sts_pkg::SUM_WIDTH-1:0];
    endfunction

    function void take_event(t_traffic_item it);
        logic [STAT_COUNT_WIDTH-1:0] hits;
        case (it.kind)
            sts_pkg::KIND_BYTE: begin
                hits = bump(bin_seen[it.byte_value] ? bin_hits[it.byte_value] : '0);
                bin_hits[it.byte_value] = hits;
                bin_seen[it.byte_value] = 1'b1;
                now.byte_total = bump(now.byte_total);
                // A tie goes to the lower byte value.
                if (hits > leader_hits || (hits == leader_hits && it.byte_value < leader_value)) begin
                    leader_hits  = hits;
                    leader_value = it.byte_value;
                end
            end
            sts_pkg::KIND_PACKET: begin
                now.packet_total = bump(now.packet_total);
                if (it.pkt_err)
                    now.bad_packets = bump(now.bad_packets);
                else
                    now.good_packets = bump(now.good_packets);
                if (it.packet_size < now.smallest_size)
                    now.smallest_size = it.packet_size;
                if (it.packet_size > now.largest_size)
                    now.largest_size = it.packet_size;
                now.size_sum = add_capped(now.size_sum, {32'd0, it.packet_size});
            end
            sts_pkg::KIND_GAP: begin
                now.gap_total = bump(now.gap_total);
                now.gap_sum   = add_capped(now.gap_sum, {16'd0, it.gap_us});
                if (it.gap_us > now.longest_gap)
                    now.longest_gap = it.gap_us;
            end
            default: wipe();
        endcase
        now.top_byte = leader_value;
        pending_snapshots.push_back(now);
    endfunction

    task report(string what, logic [63:0] got, logic [63:0] want);
        mismatch_count++;
        $display("[%0t] %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
    endtask

    task compare_field(string what, logic [63:0] got, logic [63:0] want);
        if (got !== want)
            report(what, got, want);
    endtask

    task check_snapshot(t_stats_snapshot got);
        t_stats_snapshot want;
        if (pending_snapshots.size() == 0) begin
            report("snapshot with none outstanding", 64'(got.byte_total), 64'd0);
        end else begin
            want = pending_snapshots.pop_front();
            compare_field("byte_total",    64'(got.byte_total),    64'(want.byte_total));
            compare_field("packet_total",  64'(got.packet_total),  64'(want.packet_total));
            compare_field("good_packets",  64'(got.good_packets),  64'(want.good_packets));
            compare_field("bad_packets",   64'(got.bad_packets),   64'(want.bad_packets));
            compare_field("smallest_size", 64'(got.smallest_size), 64'(want.smallest_size));
            compare_field("largest_size",  64'(got.largest_size),  64'(want.largest_size));
            compare_field("size_sum",      64'(got.size_sum),      64'(want.size_sum));
            compare_field("gap_total",     64'(got.gap_total),     64'(want.gap_total));
            compare_field("gap_sum",       64'(got.gap_sum),       64'(want.gap_sum));
            compare_field("longest_gap",   64'(got.longest_gap),   64'(want.longest_gap));
            compare_field("top_byte",      64'(got.top_byte),      64'(want.top_byte));
        end
    endtask
endclass

module tb;

    localparam int CLK_PERIOD  = 10;
    localparam int CYCLE_LIMIT = 4_000_000;
    localparam int RANDOM_BEATS = 730;
    // Beat index in the random phase at which the receiver starts its long hold-off.
    localparam int HOLD_AT_BEAT = 250;
    // Number of cycles the receiver refuses snapshots during the hold-off.
    localparam int HOLD_CYCLES = 80;
    // The final stretch runs with neither side idling.
    localparam int CALM_TAIL_BEATS = 150;

    logic                                i_clk         = 1'b0;
    logic                                i_rst_n       = 1'b0;
    logic                                push          = 1'b0;
    logic                                pop           = 1'b0;
    logic [sts_pkg::KIND_WIDTH-1:0]      i_kind        = sts_pkg::KIND_BYTE;
    logic [sts_pkg::BYTE_WIDTH-1:0]      i_byte_value  = '0;
    logic [STAT_SIZE_WIDTH-1:0]          i_packet_size = '0;
    logic                                i_pkt_err     = 1'b0;
    logic [sts_pkg::GAP_WIDTH-1:0]       i_gap_us      = '0;

    logic                                full;
    logic                                empty;
    logic [STAT_COUNT_WIDTH-1:0]         o_byte_total;
    logic [STAT_COUNT_WIDTH-1:0]         o_packet_total;
    logic [STAT_COUNT_WIDTH-1:0]         o_good_packets;
    logic [STAT_COUNT_WIDTH-1:0]         o_bad_packets;
    logic [STAT_SIZE_WIDTH-1:0]          o_smallest_size;
    logic [STAT_SIZE_WIDTH-1:0]          o_largest_size;
    logic [sts_pkg::SUM_WIDTH-1:0]       o_size_sum;
    logic [STAT_COUNT_WIDTH-1:0]         o_gap_total;
    logic [sts_pkg::SUM_WIDTH-1:0]       o_gap_sum;
    logic [sts_pkg::GAP_WIDTH-1:0]       o_longest_gap;
    logic [sts_pkg::BYTE_WIDTH-1:0]      o_top_byte;

    // Shared between the event sender and the snapshot receiver. When calm is set
    // neither side idles; hold_request asks the receiver for its long hold-off and
    // holding stays high for as long as it lasts, so the sender keeps offering beats.
    bit                                  calm         = 1'b0;
    bit                                  hold_request = 1'b0;
    bit                                  holding      = 1'b0;

    traffic_tally                        tally = new();

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    serial_traffic_statistics #(
        .COUNTER_WIDTH (STAT_COUNT_WIDTH),
        .SIZE_WIDTH    (STAT_SIZE_WIDTH)
    ) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .push            (push),
        .full            (full),
        .i_kind          (i_kind),
        .i_byte_value    (i_byte_value),
        .i_packet_size   (i_packet_size),
        .i_pkt_err       (i_pkt_err),
        .i_gap_us        (i_gap_us),
        .empty           (empty),
        .pop             (pop),
        .o_byte_total    (o_byte_total),
        .o_packet_total  (o_packet_total),
        .o_good_packets  (o_good_packets),
        .o_bad_packets   (o_bad_packets),
        .o_smallest_size (o_smallest_size),
        .o_largest_size  (o_largest_size),
        .o_size_sum      (o_size_sum),
        .o_gap_total     (o_gap_total),
        .o_gap_sum       (o_gap_sum),
        .o_longest_gap   (o_longest_gap),
        .o_top_byte      (o_top_byte)
    );

    // Builds a beat of the given kind. The value lands in the field that the kind
    // uses; every other field gets random content, since the block must ignore it.
    function automatic t_traffic_item make_item(sts_pkg::t_kind k, logic [31:0] value,
                                                logic err);
        t_traffic_item it;
        logic [31:0]   noise;
        noise          = $urandom();
        it.kind        = k;
        it.byte_value  = noise[sts_pkg::BYTE_WIDTH-1:0];
        it.packet_size = noise[STAT_SIZE_WIDTH-1:0];
        it.pkt_err     = noise[31];
        it.gap_us      = $urandom();
        case (k)
            sts_pkg::KIND_BYTE:   it.byte_value = value[sts_pkg::BYTE_WIDTH-1:0];
            sts_pkg::KIND_PACKET: begin
                it.packet_size = value[STAT_SIZE_WIDTH-1:0];
                it.pkt_err     = err;
            end
            sts_pkg::KIND_GAP:    it.gap_us = value;
            default: ;
        endcase
        return it;
    endfunction

    // Random traffic. Bytes lean on a few hot values so that the lead in the
    // histogram changes hands and ties happen often; sizes and gaps hit their
    // extremes regularly; a clear comes now and then to restart the statistics.
    function automatic t_traffic_item random_item();
        int unsigned pick;
        int unsigned flavor;
        logic [31:0] value;
        pick   = $urandom_range(0, 99);
        flavor = $urandom_range(0, 9);
        if (pick < 55) begin
            value = (flavor < 6) ? 32'h55 * $urandom_range(0, 3) : $urandom();
            return make_item(sts_pkg::KIND_BYTE, value, 1'b0);
        end else if (pick < 78) begin
            case (flavor)
                0:       value = 32'd0;
                1:       value = 32'hFFFF;
                2, 3:    value = $urandom_range(1, 64);
                default: value = $urandom();
            endcase
            return make_item(sts_pkg::KIND_PACKET, value, $urandom_range(0, 3) == 0);
        end else if (pick < 98) begin
            case (flavor)
                0:       value = 32'd0;
                1:       value = 32'hFFFF_FFFF;
                2, 3:    value = $urandom_range(1, 1000);
                default: value = $urandom();
            endcase
            return make_item(sts_pkg::KIND_GAP, value, 1'b0);
        end
        return make_item(sts_pkg::KIND_CLEAR, 32'd0, 1'b0);
    endfunction

    // Offers one event beat and waits until the block takes it. Push is left high
    // so that back-to-back beats keep it up without a glitch.
    task automatic send_event(input t_traffic_item it);
        push          <= 1'b1;
        i_kind        <= it.kind;
        i_byte_value  <= it.byte_value;
        i_packet_size <= it.packet_size;
        i_pkt_err     <= it.pkt_err;
        i_gap_us      <= it.gap_us;
        do @(posedge i_clk); while (full);
        tally.take_event(it);
    endtask

    // Random idle burst on the event side, skipped when the run is calm or while
    // the receiver holds off, since that stretch is meant to fill the block up.
    task automatic sender_idle();
        if (!calm && !hold_request && !holding && $urandom_range(0, 3) == 0) begin
            push <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge i_clk);
        end
    endtask

    task automatic wait_until_drained();
        push <= 1'b0;
        while (tally.pending_snapshots.size() != 0)
            @(posedge i_clk);
    endtask

    // Snapshot receiver. Each snapshot is taken at an edge with pop high and empty
    // low, and the outputs are read there, before the block updates them. Pop
    // then follows random runs of taking and stalling, a long hold-off on request,
    // and a steady pop once the run goes calm.
    initial begin : snapshot_sink
        t_stats_snapshot got;
        int              run_left;
        bit              run_takes;
        int              hold_left;
        run_left  = 0;
        run_takes = 1'b1;
        hold_left = 0;
        forever begin
            @(posedge i_clk);
            if (pop && !empty) begin
                got.byte_total    = o_byte_total;
                got.packet_total  = o_packet_total;
                got.good_packets  = o_good_packets;
                got.bad_packets   = o_bad_packets;
                got.smallest_size = o_smallest_size;
                got.largest_size  = o_largest_size;
                got.size_sum      = o_size_sum;
                got.gap_total     = o_gap_total;
                got.gap_sum       = o_gap_sum;
                got.longest_gap   = o_longest_gap;
                got.top_byte      = o_top_byte;
                tally.check_snapshot(got);
            end
            if (hold_request) begin
                hold_request = 1'b0;
                holding      = 1'b1;
                hold_left    = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                if (hold_left == 0)
                    holding = 1'b0;
                pop <= 1'b0;
            end else if (calm || !i_rst_n) begin
                pop <= i_rst_n;
            end else begin
                if (run_left == 0) begin
                    run_takes = ($urandom_range(0, 2) != 0);
                    run_left  = run_takes ? $urandom_range(1, 20) : $urandom_range(1, 10);
                end
                run_left--;
                pop <= run_takes;
            end
        end
    end

    // Watchdog: a run that is still going at the limit has lost snapshots or hung.
    initial begin : watchdog
        int unsigned cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("Mismatches found");
        $finish;
    end

    initial begin : event_source
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed beats. The histogram lead first goes to 0xFF, then a tie at one
        // hit hands it to the lower byte, 0xFF pulls ahead, and another tie at two
        // hits returns it to zero.
        send_event(make_item(sts_pkg::KIND_BYTE, 32'hFF, 1'b0));   sender_idle();
        send_event(make_item(sts_pkg::KIND_BYTE, 32'h00, 1'b0));   sender_idle();
        send_event(make_item(sts_pkg::KIND_BYTE, 32'hFF, 1'b0));   sender_idle();
        send_event(make_item(sts_pkg::KIND_BYTE, 32'h80, 1'b0));   sender_idle();
        send_event(make_item(sts_pkg::KIND_BYTE, 32'h00, 1'b0));   sender_idle();
        // Packet sizes and gaps at both ends of their ranges, with and without errors.
        send_event(make_item(sts_pkg::KIND_PACKET, 32'h0000, 1'b0)); sender_idle();
        send_event(make_item(sts_pkg::KIND_PACKET, 32'hFFFF, 1'b1)); sender_idle();
        send_event(make_item(sts_pkg::KIND_PACKET, 32'h0001, 1'b1)); sender_idle();
        send_event(make_item(sts_pkg::KIND_GAP, 32'h0000_0000, 1'b0)); sender_idle();
        send_event(make_item(sts_pkg::KIND_GAP, 32'hFFFF_FFFF, 1'b0)); sender_idle();
        send_event(make_item(sts_pkg::KIND_GAP, 32'h0000_0001, 1'b0)); sender_idle();
        // After a clear, an all-ones packet leaves the smallest size at all ones,
        // the same value as before any packet.
        send_event(make_item(sts_pkg::KIND_CLEAR, 32'd0, 1'b0));     sender_idle();
        send_event(make_item(sts_pkg::KIND_PACKET, 32'hFFFF, 1'b0)); sender_idle();
        send_event(make_item(sts_pkg::KIND_PACKET, 32'hFFFF, 1'b1)); sender_idle();
        send_event(make_item(sts_pkg::KIND_GAP, 32'hFFFF_FFFF, 1'b0)); sender_idle();
        send_event(make_item(sts_pkg::KIND_BYTE, 32'h01, 1'b0));     sender_idle();
        // Two clears in a row: the second one acts on statistics that are already clear.
        send_event(make_item(sts_pkg::KIND_CLEAR, 32'd0, 1'b0));     sender_idle();
        send_event(make_item(sts_pkg::KIND_CLEAR, 32'd0, 1'b0));     sender_idle();
        // Alternating bit patterns in every field.
        send_event(make_item(sts_pkg::KIND_BYTE, 32'hAA, 1'b0));     sender_idle();
        send_event(make_item(sts_pkg::KIND_BYTE, 32'h55, 1'b0));     sender_idle();
        send_event(make_item(sts_pkg::KIND_PACKET, 32'h5555, 1'b0)); sender_idle();
        send_event(make_item(sts_pkg::KIND_PACKET, 32'hAAAA, 1'b1)); sender_idle();
        send_event(make_item(sts_pkg::KIND_GAP, 32'hAAAA_AAAA, 1'b0)); sender_idle();
        send_event(make_item(sts_pkg::KIND_GAP, 32'h5555_5555, 1'b0));

        // The sender pauses here until every snapshot so far has come out.
        wait_until_drained();

        // Random traffic. Partway through, the receiver holds off for a long stretch
        // while beats keep coming, so both queues fill and full stalls the sender.
        for (int n = 0; n < RANDOM_BEATS; n++) begin
            if (n == HOLD_AT_BEAT)
                hold_request = 1'b1;
            if (n == RANDOM_BEATS - CALM_TAIL_BEATS)
                calm = 1'b1;
            send_event(random_item());
            sender_idle();
        end

        // Let the last snapshots come out, then keep popping so that any stray extra
        // snapshot gets caught.
        wait_until_drained();
        repeat (10) @(posedge i_clk);
        if (tally.pending_snapshots.size() != 0)
            tally.report("snapshots never delivered",
                         64'(tally.pending_snapshots.size()), 64'd0);

        if (tally.mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
